>>> sv/wrsd_pkg.sv
// Shared types, constants and reset values for the windowed RMS signal detector.
`timescale 1ns / 1ps
`default_nettype none

package wrsd_pkg;

    // Default build-time sizes
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WINDOW_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 8;

    // Fixed widths of the window arithmetic
    localparam int ACC_BITS       = 48;
    localparam int DIVISOR_BITS   = 32;
    localparam int RAD_BITS       = 48;
    localparam int THRESH_BITS    = 15;
    localparam int PCT_BITS       = 15;
    localparam int SCALE_BITS     = 15;
    localparam int M_TDATA_BITS   = 24;

    // Q8.8 percent scale: 100 * 256
    localparam logic [SCALE_BITS-1:0] PCT_SCALE = 15'd25600;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam int                      WINDOW_RESET = 1024;
    localparam int                      SUCC_RESET   = 4;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 15'd256;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WINDOW     = 2'd0,
        CFG_SUCCESSION = 2'd1,
        CFG_THRESHOLD  = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_SCALE,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_UPDATE
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic accum;
        logic mean_go;
        logic sqrt_go;
        logic scale;
        logic pct_go;
        logic update;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic win_end;
        logic div_done;
        logic sqrt_done;
        logic pct_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/wrsd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module wrsd_div #(
    parameter int N_BITS = wrsd_pkg::ACC_BITS,
    parameter int D_BITS = wrsd_pkg::DIVISOR_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [N_BITS-1:0] dividend,
    input  wire logic [D_BITS-1:0] divisor,
    output logic                   done,
    output logic [N_BITS-1:0]      quotient
);

    localparam int CNT_BITS = $clog2(N_BITS);

    logic [N_BITS-1:0]   quo_reg, quo_next;
    logic [D_BITS-1:0]   rem_reg, rem_next;
    logic [D_BITS-1:0]   dvs_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [D_BITS:0] rem_sh;
    logic [D_BITS:0] diff;
    logic            fits;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        rem_sh   = {rem_reg, quo_reg[N_BITS-1]};
        diff     = rem_sh - {1'b0, dvs_reg};
        fits     = (rem_sh >= {1'b0, dvs_reg});
        rem_next = fits ? diff[D_BITS-1:0] : rem_sh[D_BITS-1:0];
        quo_next = {quo_reg[N_BITS-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(N_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> sv/wrsd_isqrt.sv
// Integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module wrsd_isqrt #(
    parameter int RAD_BITS = wrsd_pkg::RAD_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [RAD_BITS-1:0]   radicand,
    output logic                       done,
    output logic [RAD_BITS/2-1:0]      root
);

    localparam int ROOT_BITS = RAD_BITS / 2;
    localparam int REM_BITS  = ROOT_BITS + 3;
    localparam int CNT_BITS  = $clog2(ROOT_BITS);

    logic [RAD_BITS-1:0]  rad_reg, rad_next;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [REM_BITS-1:0] rem_sh;
    logic [REM_BITS-1:0] trial;
    logic                fits;

    // Bring down the next bit pair and try 4*root+1
    always_comb begin
        rem_sh    = {rem_reg[REM_BITS-3:0], rad_reg[RAD_BITS-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        fits      = (rem_sh >= trial);
        rem_next  = fits ? (rem_sh - trial) : rem_sh;
        root_next = {root_reg[ROOT_BITS-2:0], fits};
        rad_next  = {rad_reg[RAD_BITS-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rad_reg  <= rad_next;
                rem_reg  <= rem_next;
                root_reg <= root_next;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(ROOT_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

>>> sv/wrsd_dp.sv
// Datapath: configuration, window accumulation, RMS math, hysteresis and output word.
`timescale 1ns / 1ps
`default_nettype none

module wrsd_dp #(
    parameter int SAMPLE_BITS = wrsd_pkg::SAMPLE_BITS_DEF,
    parameter int WINDOW_BITS = wrsd_pkg::WINDOW_BITS_DEF,
    parameter int COUNT_BITS  = wrsd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire wrsd_pkg::ctrl_cmd_t                   cmd,
    output wrsd_pkg::dp_stat_t                         stat,
    input  wire logic signed [SAMPLE_BITS-1:0]         left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]         right_sample,
    input  wire logic                                  cfg_we,
    input  wire logic [wrsd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [wrsd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [wrsd_pkg::M_TDATA_BITS-1:0]          out_data
);

    localparam int ACC_BITS   = wrsd_pkg::ACC_BITS;
    localparam int DVS_BITS   = wrsd_pkg::DIVISOR_BITS;
    localparam int RAD_BITS   = wrsd_pkg::RAD_BITS;
    localparam int ROOT_BITS  = RAD_BITS / 2;
    localparam int PROD_BITS  = ROOT_BITS + wrsd_pkg::SCALE_BITS;
    localparam int MAG_BITS   = SAMPLE_BITS + 1;
    localparam int SQ_BITS    = 2 * MAG_BITS;
    localparam int LOUD_BITS  = COUNT_BITS + 1;
    localparam int TAKE_BITS  = WINDOW_BITS + 1;
    localparam int PCT_BITS   = wrsd_pkg::PCT_BITS;
    localparam int THR_BITS   = wrsd_pkg::THRESH_BITS;
    localparam int PAD_BITS   = wrsd_pkg::M_TDATA_BITS - PCT_BITS - 2;
    localparam int PCT_SHIFT  = SAMPLE_BITS - 1;

    // Full-scale sample value, 2^(SAMPLE_BITS-1) - 1, also the low-bit mask for folding
    localparam logic [PROD_BITS-1:0] FULL_SCALE =
        PROD_BITS'((64'd1 << PCT_SHIFT) - 64'd1);
    localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Configuration registers
    logic [WINDOW_BITS-1:0] window_frames_reg;
    logic [COUNT_BITS-1:0]  succession_reg;
    logic [THR_BITS-1:0]    threshold_reg;

    // Window state
    logic [ACC_BITS-1:0]    acc_reg;
    logic [SQ_BITS-1:0]     sq_reg;
    logic [WINDOW_BITS-1:0] frame_index_reg;
    logic [TAKE_BITS-1:0]   taken_reg;
    logic                   clip_reg;
    logic [LOUD_BITS-1:0]   loud_reg, loud_next;
    logic                   sig_reg, sig_next;
    logic [PROD_BITS-1:0]   prod_reg;

    // Percent scaling by the full-scale value
    logic [PROD_BITS-1:0]   fold_rem_reg;
    logic [PROD_BITS-1:0]   pct_reg;
    logic                   fold_busy_reg;
    logic [PROD_BITS-1:0]   fold_hi;
    logic [PROD_BITS-1:0]   fold_lo;
    logic                   pct_done;

    // Output word
    logic                   out_valid_reg;
    logic [PCT_BITS-1:0]    out_pct_reg;
    logic                   out_sig_reg;
    logic                   out_clip_reg;

    logic signed [MAG_BITS-1:0] mix;
    logic [MAG_BITS-1:0]        mag;
    logic                       clip_now;
    logic [TAKE_BITS-1:0]       taken;
    logic [TAKE_BITS-1:0]       frames_eff;

    logic                div_start;
    logic [ACC_BITS-1:0] div_dividend;
    logic [DVS_BITS-1:0] div_divisor;
    logic                div_done;
    logic [ACC_BITS-1:0] div_quo;
    logic                sqrt_done;
    logic [ROOT_BITS-1:0] sqrt_root;
    logic                loud;
    logic [LOUD_BITS-1:0] succ_ext;

    // Mono mix magnitude and full-scale check of the incoming frame
    always_comb begin
        mix      = MAG_BITS'(left_sample) + MAG_BITS'(right_sample);
        mag      = mix[MAG_BITS-1] ? MAG_BITS'(-mix) : MAG_BITS'(mix);
        clip_now = (left_sample == SMP_MAX) || (left_sample == SMP_MIN) ||
                   (right_sample == SMP_MAX) || (right_sample == SMP_MIN);
    end

    // Frames taken including this one, and window length with zero as one
    always_comb begin
        taken      = TAKE_BITS'(frame_index_reg) + 1'b1;
        frames_eff = (window_frames_reg == '0) ? TAKE_BITS'(1)
                                               : TAKE_BITS'(window_frames_reg);
    end

    // Divider for the window mean over the frames taken
    always_comb begin
        div_start    = cmd.mean_go;
        div_dividend = acc_reg;
        div_divisor  = DVS_BITS'(taken_reg);
    end

    wrsd_div #(
        .N_BITS (ACC_BITS),
        .D_BITS (DVS_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Root of sum / (4 * taken): drop two quotient bits
    wrsd_isqrt #(
        .RAD_BITS (RAD_BITS)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_go),
        .radicand ({2'b00, div_quo[ACC_BITS-1:2]}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Split the remainder at the full-scale width; done once it is below full scale
    always_comb begin
        fold_hi  = fold_rem_reg >> PCT_SHIFT;
        fold_lo  = fold_rem_reg & FULL_SCALE;
        pct_done = fold_busy_reg && (fold_hi == '0) && (fold_rem_reg != FULL_SCALE);
    end

    // Divide by 2^k - 1: fold the high part back onto the low part and count it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_busy_reg <= 1'b0;
        end else if (cmd.pct_go) begin
            fold_busy_reg <= 1'b1;
            fold_rem_reg  <= prod_reg;
            pct_reg       <= '0;
        end else if (fold_busy_reg) begin
            if (fold_hi != '0) begin
                pct_reg      <= pct_reg + fold_hi;
                fold_rem_reg <= fold_lo + fold_hi;
            end else if (fold_rem_reg == FULL_SCALE) begin
                pct_reg      <= pct_reg + 1'b1;
                fold_rem_reg <= '0;
            end else begin
                fold_busy_reg <= 1'b0;
            end
        end
    end

    // Hysteresis counter and state on the finished percent
    always_comb begin
        loud      = (pct_reg >= PROD_BITS'(threshold_reg));
        succ_ext  = LOUD_BITS'(succession_reg);
        loud_next = loud_reg;
        sig_next  = sig_reg;
        if (!loud) begin
            if (loud_reg != '0) begin
                loud_next = loud_reg - 1'b1;
                if ((loud_next == '0) && sig_reg) begin
                    sig_next = 1'b0;
                end
            end
        end else begin
            if (loud_reg <= succ_ext) begin
                loud_next = loud_reg + 1'b1;
                if ((loud_next == succ_ext) && !sig_reg) begin
                    sig_next = 1'b1;
                end
            end
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_frames_reg <= WINDOW_BITS'(wrsd_pkg::WINDOW_RESET);
            succession_reg    <= COUNT_BITS'(wrsd_pkg::SUCC_RESET);
            threshold_reg     <= wrsd_pkg::THRESH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                wrsd_pkg::CFG_WINDOW:     window_frames_reg <= cfg_data[WINDOW_BITS-1:0];
                wrsd_pkg::CFG_SUCCESSION: succession_reg    <= cfg_data[COUNT_BITS-1:0];
                wrsd_pkg::CFG_THRESHOLD:  threshold_reg     <= cfg_data[THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Window accumulation, hysteresis state and clear at window end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg         <= '0;
            frame_index_reg <= '0;
            clip_reg        <= 1'b0;
            loud_reg        <= '0;
            sig_reg         <= 1'b0;
        end else begin
            if (cmd.accept) begin
                sq_reg <= SQ_BITS'(mag) * SQ_BITS'(mag);
                if (clip_now) begin
                    clip_reg <= 1'b1;
                end
            end
            if (cmd.accum) begin
                acc_reg   <= acc_reg + ACC_BITS'(sq_reg);
                taken_reg <= taken;
                if (taken < frames_eff) begin
                    frame_index_reg <= taken[WINDOW_BITS-1:0];
                end else begin
                    frame_index_reg <= '0;
                end
            end
            if (cmd.scale) begin
                prod_reg <= PROD_BITS'(sqrt_root) * PROD_BITS'(wrsd_pkg::PCT_SCALE);
            end
            if (cmd.update) begin
                loud_reg <= loud_next;
                sig_reg  <= sig_next;
                acc_reg  <= '0;
                clip_reg <= 1'b0;
            end
        end
    end

    // Output register: hold the word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.update) begin
                out_valid_reg <= 1'b1;
                out_pct_reg   <= pct_reg[PCT_BITS-1:0];
                out_sig_reg   <= sig_next;
                out_clip_reg  <= clip_reg;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.win_end   = !(taken < frames_eff);
        stat.div_done  = div_done;
        stat.sqrt_done = sqrt_done;
        stat.pct_done  = pct_done;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{PAD_BITS{1'b0}}, out_clip_reg, out_sig_reg, out_pct_reg};

endmodule

`default_nettype wire

>>> sv/wrsd_ctrl.sv
// Controller: sequences frame accumulation and the window-end computation.
`timescale 1ns / 1ps
`default_nettype none

module wrsd_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire wrsd_pkg::dp_stat_t   stat,
    output wrsd_pkg::ctrl_cmd_t       cmd
);

    wrsd_pkg::ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wrsd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            wrsd_pkg::ST_IDLE: begin
                in_ready   = aresetn;
                cmd.accept = in_valid && aresetn;
                if (cmd.accept) begin
                    state_next = wrsd_pkg::ST_ACCUM;
                end
            end
            wrsd_pkg::ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = stat.win_end ? wrsd_pkg::ST_MEAN_GO : wrsd_pkg::ST_IDLE;
            end
            wrsd_pkg::ST_MEAN_GO: begin
                cmd.mean_go = 1'b1;
                state_next  = wrsd_pkg::ST_MEAN_WAIT;
            end
            wrsd_pkg::ST_MEAN_WAIT: begin
                if (stat.div_done) begin
                    state_next = wrsd_pkg::ST_SQRT_GO;
                end
            end
            wrsd_pkg::ST_SQRT_GO: begin
                cmd.sqrt_go = 1'b1;
                state_next  = wrsd_pkg::ST_SQRT_WAIT;
            end
            wrsd_pkg::ST_SQRT_WAIT: begin
                if (stat.sqrt_done) begin
                    state_next = wrsd_pkg::ST_SCALE;
                end
            end
            wrsd_pkg::ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = wrsd_pkg::ST_PCT_GO;
            end
            wrsd_pkg::ST_PCT_GO: begin
                cmd.pct_go = 1'b1;
                state_next = wrsd_pkg::ST_PCT_WAIT;
            end
            wrsd_pkg::ST_PCT_WAIT: begin
                if (stat.pct_done) begin
                    state_next = wrsd_pkg::ST_UPDATE;
                end
            end
            wrsd_pkg::ST_UPDATE: begin
                // Wait for the output slot, then commit the window result
                if (stat.out_free) begin
                    cmd.update = 1'b1;
                    state_next = wrsd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wrsd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/windowed_rms_signal_detector.sv
// Top level of the windowed RMS signal detector.
`timescale 1ns / 1ps
`default_nettype none

// Takes one stereo frame per input word and squares the left plus right sum into a
// 48-bit window sum; a frame that does not close the window is accepted and then
// accumulated. The frame that closes the window holds off the next frame until its
// result is committed: the divider, one quotient bit per cycle, divides the window
// sum by the frames taken, the square root settles two radicand bits per cycle, and
// the Q8.8 percent is scaled and then divided by the full-scale value by folding.
// The result word is held in an output register, so the run may end while the
// previous result is still waiting; a new result waits there only if that word is
// still held.
// Configuration writes are taken at any cycle and should be made between windows.
module windowed_rms_signal_detector #(
    parameter int SAMPLE_BITS = wrsd_pkg::SAMPLE_BITS_DEF,
    parameter int WINDOW_BITS = wrsd_pkg::WINDOW_BITS_DEF,
    parameter int COUNT_BITS  = wrsd_pkg::COUNT_BITS_DEF,
    localparam int S_TDATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // tdata: left_sample, right_sample (from bit 0 up), zero padded
    input  wire logic [S_TDATA_BITS-1:0]               s_axis_tdata,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata: rms_percent[14:0], signal_present, clipped (from bit 0 up), zero padded
    output logic [wrsd_pkg::M_TDATA_BITS-1:0]          m_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [wrsd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [wrsd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    wrsd_pkg::ctrl_cmd_t cmd;
    wrsd_pkg::dp_stat_t  stat;

    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    // Unpack the input word
    assign left_sample  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign right_sample = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign cfg_ready    = 1'b1;

    wrsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wrsd_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW_BITS (WINDOW_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata)
    );

    // A result is never committed over a word still waiting at the output
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> (!m_axis_tvalid || m_axis_tready))
        else $error("window result committed over a held output word");

    // An accepted frame is accumulated in the following cycle
    a_accum_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> cmd.accum)
        else $error("accepted frame was not accumulated");

    // No frame is taken while the window-end computation runs
    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.div_done || stat.sqrt_done || cmd.mean_go || cmd.pct_go) |-> !s_axis_tready)
        else $error("frame accepted during window computation");

    // A result word appears only right after a committed window
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(cmd.update))
        else $error("output word raised without a committed window");

endmodule

`default_nettype wire
